@@ rtl/vbsa_pkg.sv @@
// Shared types and constants for the vertex buffer stride allocator.
// Holds the payload structs, register and status codes, and the
// controller/datapath command and status groups. No dependencies.
package vbsa_pkg;

    localparam int ADDR_BITS  = 24;
    localparam int CAP_W      = 25;
    localparam int COUNT_W    = 16;
    localparam int STRIDE_W   = 9;
    localparam int MARGIN_W   = 8;
    localparam int OFF_W      = CAP_W + 1;
    localparam int SUM_W      = CAP_W + 2;
    localparam int DIV_STEPS  = CAP_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int PADDR_W    = 4;

    localparam logic [1:0] STATUS_PLACED  = 2'd0;
    localparam logic [1:0] STATUS_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED = 2'd2;

    localparam logic [1:0] REG_BUFFER_BYTES = 2'd0;
    localparam logic [1:0] REG_RING_MODE    = 2'd1;
    localparam logic [1:0] REG_WRAP_MARGIN  = 2'd2;

    localparam logic [CAP_W-1:0]    BUFFER_BYTES_RESET = 25'd1048576;
    localparam logic                RING_MODE_RESET    = 1'b1;
    localparam logic [MARGIN_W-1:0] WRAP_MARGIN_RESET  = 8'd64;

    typedef struct packed {
        logic [COUNT_W-1:0]  vertex_count;
        logic [STRIDE_W-1:0] vertex_stride;
        logic                already_placed;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] vertex_position;
        logic [ADDR_BITS-1:0] byte_offset;
        logic                 discard;
        logic                 past_capacity;
    } out_item_t;

    typedef struct packed {
        logic [CAP_W-1:0]    buffer_bytes;
        logic                ring_mode;
        logic [MARGIN_W-1:0] wrap_margin;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_ALIGN,
        S_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic check;
        logic div_start;
        logic div_step;
        logic align;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic early_done;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/vertex_buffer_stride_allocator_core.sv @@
// Top level of the vertex buffer stride allocator: register port,
// controller and datapath. Depends on vbsa_pkg, vbsa_ctrl, vbsa_datapath.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    vbsa_pkg::in_item_t
//   m_        out        m_valid / m_ready    vbsa_pkg::out_item_t
//   APB       in/out     psel/penable/pready  buffer_bytes, ring_mode, wrap_margin
//
// A placed run that does not wrap goes from acceptance through one multiply,
// one check, 25 steps of the serial divider, one align and one commit.
// Skipped, refused and wrapped runs bypass the divider and go from check to commit.
// The next request is taken no earlier than the cycle after a result is
// registered, so the block works on one request at a time.
// A result waiting on m_ready stalls only the commit of the following request.
// Reset clears the offsets, the output valid and the registers to their defaults.
module vertex_buffer_stride_allocator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  vbsa_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output vbsa_pkg::out_item_t              m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vbsa_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    vbsa_pkg::cfg_t       cfg_reg, cfg_next;
    vbsa_pkg::ctrl_cmd_t  cmd;
    vbsa_pkg::dp_status_t status;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (paddr[3:2])
                vbsa_pkg::REG_BUFFER_BYTES:
                    cfg_next.buffer_bytes = pwdata[vbsa_pkg::CAP_W-1:0];
                vbsa_pkg::REG_RING_MODE:
                    cfg_next.ring_mode = pwdata[0];
                vbsa_pkg::REG_WRAP_MARGIN:
                    cfg_next.wrap_margin = pwdata[vbsa_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            vbsa_pkg::REG_BUFFER_BYTES: prdata = 32'(cfg_reg.buffer_bytes);
            vbsa_pkg::REG_RING_MODE:    prdata = 32'(cfg_reg.ring_mode);
            vbsa_pkg::REG_WRAP_MARGIN:  prdata = 32'(cfg_reg.wrap_margin);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.buffer_bytes <= vbsa_pkg::BUFFER_BYTES_RESET;
            cfg_reg.ring_mode    <= vbsa_pkg::RING_MODE_RESET;
            cfg_reg.wrap_margin  <= vbsa_pkg::WRAP_MARGIN_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    vbsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    vbsa_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data),
        .m_valid (m_valid)
    );

endmodule

@@ rtl/vbsa_divider.sv @@
// Restoring serial divider: one quotient bit per step, DIV_STEPS steps.
// Depends on vbsa_pkg for widths.
module vbsa_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic                           step,
    input  logic [vbsa_pkg::CAP_W-1:0]     dividend,
    input  logic [vbsa_pkg::STRIDE_W-1:0]  divisor,
    output logic [vbsa_pkg::CAP_W-1:0]     quotient,
    output logic [vbsa_pkg::STRIDE_W-1:0]  remainder,
    output logic                           last
);

    logic [vbsa_pkg::CAP_W-1:0]     quo_reg, quo_next;
    logic [vbsa_pkg::STRIDE_W-1:0]  rem_reg, rem_next;
    logic [vbsa_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [vbsa_pkg::STRIDE_W:0]    trial;
    logic                           ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[vbsa_pkg::CAP_W-1]};
        ge       = trial >= {1'b0, divisor};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = '0;
        end else if (step) begin
            // For a nonzero divisor, the partial remainder stays below the divisor.
            rem_next = ge ? vbsa_pkg::STRIDE_W'(trial - {1'b0, divisor})
                          : trial[vbsa_pkg::STRIDE_W-1:0];
            quo_next = {quo_reg[vbsa_pkg::CAP_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign last      = cnt_reg == vbsa_pkg::DIV_CNT_W'(vbsa_pkg::DIV_STEPS - 1);

endmodule

@@ rtl/vbsa_ctrl.sv @@
// Controller state machine for the allocator.
// Sequences multiply, check, divide, align and commit; early-done runs go from check to commit. Depends on vbsa_pkg.
module vbsa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  vbsa_pkg::dp_status_t status,
    output vbsa_pkg::ctrl_cmd_t  cmd,
    output logic                 s_ready
);

    vbsa_pkg::ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vbsa_pkg::S_IDLE: begin
                if (s_valid) state_next = vbsa_pkg::S_MUL;
            end
            vbsa_pkg::S_MUL:   state_next = vbsa_pkg::S_CHECK;
            vbsa_pkg::S_CHECK: begin
                state_next = status.early_done ? vbsa_pkg::S_COMMIT : vbsa_pkg::S_DIV;
            end
            vbsa_pkg::S_DIV: begin
                if (status.div_last) state_next = vbsa_pkg::S_ALIGN;
            end
            vbsa_pkg::S_ALIGN: state_next = vbsa_pkg::S_COMMIT;
            vbsa_pkg::S_COMMIT: begin
                if (status.out_free) state_next = vbsa_pkg::S_IDLE;
            end
            default: state_next = vbsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            vbsa_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            vbsa_pkg::S_MUL:   cmd.mul = 1'b1;
            vbsa_pkg::S_CHECK: begin
                cmd.check     = 1'b1;
                cmd.div_start = 1'b1;
            end
            vbsa_pkg::S_DIV:    cmd.div_step = 1'b1;
            vbsa_pkg::S_ALIGN:  cmd.align    = 1'b1;
            vbsa_pkg::S_COMMIT: cmd.commit   = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vbsa_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/vbsa_datapath.sv @@
// Datapath: request registers, size multiply, room checks, alignment,
// offset state and the output register. Depends on vbsa_pkg, vbsa_divider.
module vbsa_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vbsa_pkg::cfg_t       cfg,
    input  vbsa_pkg::in_item_t   s_data,
    input  logic                 m_ready,
    input  vbsa_pkg::ctrl_cmd_t  cmd,
    output vbsa_pkg::dp_status_t status,
    output vbsa_pkg::out_item_t  m_data,
    output logic                 m_valid
);

    localparam int CAP_W = vbsa_pkg::CAP_W;
    localparam int OFF_W = vbsa_pkg::OFF_W;
    localparam int SUM_W = vbsa_pkg::SUM_W;

    logic [vbsa_pkg::COUNT_W-1:0]  count_reg;
    logic [vbsa_pkg::STRIDE_W-1:0] stride_reg;
    logic                          placed_reg;
    logic [CAP_W-1:0]              bytes_reg;
    logic [1:0]                    res_status_reg;
    logic [OFF_W-1:0]              off_reg;
    logic [OFF_W-1:0]              vert_reg;
    logic                          disc_reg;
    logic [CAP_W-1:0]              next_byte_reg, next_byte_next;
    logic [CAP_W-1:0]              next_vertex_reg, next_vertex_next;
    vbsa_pkg::out_item_t           m_data_reg, m_data_next;
    logic                          m_valid_reg, m_valid_next;

    logic [SUM_W-1:0]              cap_ext, end_static, end_ring;
    logic                          skip, refuse, wrap;
    logic [CAP_W-1:0]              quotient;
    logic [vbsa_pkg::STRIDE_W-1:0] remainder;
    logic                          div_last;
    logic [SUM_W-1:0]              off_end, vert_end;
    logic                          is_placed;

    vbsa_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .dividend  (next_byte_reg),
        .divisor   (stride_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .last      (div_last)
    );

    always_comb begin
        cap_ext    = SUM_W'(cfg.buffer_bytes);
        end_static = SUM_W'(next_byte_reg) + SUM_W'(bytes_reg);
        end_ring   = end_static + SUM_W'(cfg.wrap_margin);
        skip       = !cfg.ring_mode && placed_reg;
        refuse     = (stride_reg == '0) || (SUM_W'(bytes_reg) > cap_ext) ||
                     (!cfg.ring_mode && (end_static > cap_ext));
        wrap       = cfg.ring_mode && (end_ring > cap_ext);
        off_end    = SUM_W'(off_reg) + SUM_W'(bytes_reg);
        vert_end   = SUM_W'(vert_reg) + SUM_W'(count_reg);
        is_placed  = res_status_reg == vbsa_pkg::STATUS_PLACED;
    end

    assign status.early_done = skip || refuse || wrap;
    assign status.div_last   = div_last;
    assign status.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        next_byte_next   = next_byte_reg;
        next_vertex_next = next_vertex_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg;
        if (m_ready) m_valid_next = 1'b0;
        if (cmd.commit) begin
            m_valid_next                = 1'b1;
            m_data_next.status          = res_status_reg;
            m_data_next.vertex_position = vert_reg[vbsa_pkg::ADDR_BITS-1:0];
            m_data_next.byte_offset     = off_reg[vbsa_pkg::ADDR_BITS-1:0];
            m_data_next.discard         = disc_reg;
            m_data_next.past_capacity   = is_placed && (off_end > cap_ext);
            if (is_placed) begin
                // Both offsets saturate at the top of their range.
                next_byte_next   = (|off_end[SUM_W-1:CAP_W]) ? '1 : off_end[CAP_W-1:0];
                next_vertex_next = (|vert_end[SUM_W-1:CAP_W]) ? '1 : vert_end[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            count_reg  <= s_data.vertex_count;
            stride_reg <= s_data.vertex_stride;
            placed_reg <= s_data.already_placed;
        end
        if (cmd.mul) begin
            bytes_reg <= CAP_W'(count_reg) * CAP_W'(stride_reg);
        end
        if (cmd.check) begin
            if (skip) begin
                res_status_reg <= vbsa_pkg::STATUS_SKIPPED;
            end else if (refuse) begin
                res_status_reg <= vbsa_pkg::STATUS_REFUSED;
            end else begin
                res_status_reg <= vbsa_pkg::STATUS_PLACED;
            end
            // A wrapped run starts at zero; refused and skipped runs report zero.
            off_reg  <= '0;
            vert_reg <= '0;
            disc_reg <= !skip && !refuse && wrap;
        end
        if (cmd.align) begin
            if (remainder != '0) begin
                off_reg  <= OFF_W'(next_byte_reg) + OFF_W'(stride_reg - remainder);
                vert_reg <= OFF_W'(quotient) + 1'b1;
            end else begin
                off_reg  <= OFF_W'(next_byte_reg);
                vert_reg <= OFF_W'(quotient);
            end
        end
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_byte_reg   <= '0;
            next_vertex_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            next_byte_reg   <= next_byte_next;
            next_vertex_reg <= next_vertex_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

endmodule

@@ rtl/vbsa_checker.sv @@
// Port-level checks for the allocator, bound to the top level.
// Depends on vbsa_pkg and vertex_buffer_stride_allocator_core.
module vbsa_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input vbsa_pkg::out_item_t m_data,
    input logic                m_valid,
    input logic                m_ready
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Refused and skipped runs report no position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != vbsa_pkg::STATUS_PLACED) |->
        (m_data.byte_offset == '0) && (m_data.vertex_position == '0) &&
        !m_data.discard && !m_data.past_capacity)
        else $error("non-placed result carries position fields");

    // A wrap always restarts at offset zero on a placed run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.discard |->
        (m_data.status == vbsa_pkg::STATUS_PLACED) &&
        (m_data.byte_offset == '0) && (m_data.vertex_position == '0))
        else $error("discard without restart at zero");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every request needs at least the multiply and check cycles.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared one cycle after a request");

endmodule

bind vertex_buffer_stride_allocator_core vbsa_checker u_vbsa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_data  (m_data),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
